FILE: src/r256_pkg.sv
// ----------------------------------------------------------------------------
// r256_pkg
// Shared types, constants and byte-level functions for the 256-bit-block
// Rijndael core: S-box tables, GF(2^8) constant multiplies, row shifts and
// column mixing over a 4x8 byte state.
// ----------------------------------------------------------------------------
package r256_pkg;

  localparam int unsigned RoundKeyCount = 30;
  localparam int unsigned NumRounds     = 14;
  localparam int unsigned BlockBits     = 256;
  localparam int unsigned Banks         = 4;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_KEXP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef logic [BlockBits-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Row rotation amounts for the 8-column state
  localparam int unsigned ROW_SHIFT [4] = '{0, 1, 3, 4};

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul3(input logic [7:0] b);
    mul3 = xt(b) ^ b;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] b);
    mul9 = xt(xt(xt(b))) ^ b;
  endfunction

  function automatic logic [7:0] mulb(input logic [7:0] b);
    mulb = xt(xt(xt(b))) ^ xt(b) ^ b;
  endfunction

  function automatic logic [7:0] muld(input logic [7:0] b);
    muld = xt(xt(xt(b))) ^ xt(xt(b)) ^ b;
  endfunction

  function automatic logic [7:0] mule(input logic [7:0] b);
    mule = xt(xt(xt(b))) ^ xt(xt(b)) ^ xt(b);
  endfunction

  // Schedule word transform: rotate, substitute, add round constant
  function automatic logic [31:0] sched_word(input logic [31:0] w, input logic [7:0] rc);
    sched_word = {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rc};
  endfunction

  // Forward shift then substitute (byte-wise steps commute)
  function automatic block_t shift_sub(input block_t s);
    block_t t;
    int unsigned src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 8; c++) begin
        src = (c + ROW_SHIFT[r]) % 8;
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*src) +: 8]];
      end
    end
    shift_sub = t;
  endfunction

  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    int unsigned src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 8; c++) begin
        src = (c + 8 - ROW_SHIFT[r]) % 8;
        t[8*(r+4*c) +: 8] = INV_SBOX[s[8*(r+4*src) +: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 8; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      t[32*c +: 8]    = xt(a0) ^ mul3(a1) ^ a2 ^ a3;
      t[32*c+8 +: 8]  = xt(a1) ^ mul3(a2) ^ a3 ^ a0;
      t[32*c+16 +: 8] = xt(a2) ^ mul3(a3) ^ a0 ^ a1;
      t[32*c+24 +: 8] = xt(a3) ^ mul3(a0) ^ a1 ^ a2;
    end
    mix = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 8; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      t[32*c +: 8]    = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
      t[32*c+8 +: 8]  = mule(a1) ^ mulb(a2) ^ muld(a3) ^ mul9(a0);
      t[32*c+16 +: 8] = mule(a2) ^ mulb(a3) ^ muld(a0) ^ mul9(a1);
      t[32*c+24 +: 8] = mule(a3) ^ mulb(a0) ^ muld(a1) ^ mul9(a2);
    end
    inv_mix = t;
  endfunction

endpackage

FILE: src/rijndael256_block_cipher.sv
// ----------------------------------------------------------------------------
// rijndael256_block_cipher
// Rijndael, 256-bit block, 128-bit key, 14 rounds, encrypt and decrypt.
// ----------------------------------------------------------------------------
// After reset and after every key register write the core expands the key
// into 15 round keys of 256 bits, one 32-bit schedule word per cycle, with
// in_ready low. The round keys live in four 64-bit RAM banks so that one
// whole 256-bit round key is read per cycle. A block then goes from transfer
// to result in order: the first round key is read at the transfer edge, the
// shared round unit applies the initial key addition and the 14 rounds, and
// the result moves to the output register. The core returns to idle with the
// move to the output register, so it takes no new block while one is in
// process; the move to the output register waits while an earlier result
// is still held there. The output register holds a result while the next
// block is accepted and processed.
module rijndael256_block_cipher
  import r256_pkg::*;
#(
  parameter int unsigned ROUND_KEY_COUNT = RoundKeyCount
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [63:0] in_block_word0,
  input  logic [63:0] in_block_word1,
  input  logic [63:0] in_block_word2,
  input  logic [63:0] in_block_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2,
  output logic [63:0] out_word3
);

  localparam int unsigned SchedWords = ROUND_KEY_COUNT * 4;
  localparam int unsigned IW         = $clog2(SchedWords);
  localparam int unsigned BankDepth  = ROUND_KEY_COUNT / 2;
  localparam int unsigned AW         = $clog2(BankDepth);
  localparam logic [3:0]  LastRound  = 4'(NumRounds);

  state_t            state_r, state_nxt;
  logic [63:0]       key_lo_r, key_hi_r;
  logic [IW-1:0]     idx_r;
  logic [7:0]        rc_r;
  logic [31:0]       win_r [4];
  logic [31:0]       lo_r;
  logic [31:0]       new_word;
  logic [31:0]       key_word;
  logic [127:0]      key_all;
  logic              cfg_wr;
  logic              in_xfer;
  logic              op_r;
  logic [3:0]        rnd_r;
  block_t            st_r, round_out, enc_a, dec_a, rk;
  logic [255:0]      out_r;
  logic              out_valid_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [Banks-1:0]  bank_we;
  logic [63:0]       bank_rd [Banks];
  logic [3:0]        next_key;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = cfg_paddr[3] ? key_hi_r : key_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) key_hi_r <= cfg_pwdata;
      else key_lo_r <= cfg_pwdata;
    end
  end

  // Key schedule: one word per cycle over a four-word window
  assign key_all  = {key_hi_r, key_lo_r};
  assign key_word = key_all[32*idx_r[1:0] +: 32];

  always_comb begin
    if (idx_r < IW'(4)) begin
      new_word = key_word;
    end else if (idx_r[1:0] == 2'd0) begin
      new_word = win_r[0] ^ sched_word(win_r[3], rc_r);
    end else begin
      new_word = win_r[0] ^ win_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KEXP) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= new_word;
      if (!idx_r[0]) lo_r <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      idx_r <= '0;
      rc_r  <= 8'h01;
    end else if (state_r == ST_KEXP) begin
      idx_r <= (idx_r == IW'(SchedWords - 1)) ? '0 : idx_r + 1'b1;
      if (idx_r >= IW'(4) && idx_r[1:0] == 2'd0) rc_r <= xt(rc_r);
    end
  end

  // Store a 64-bit word after every odd schedule word
  assign wr_addr = AW'(idx_r >> 3);
  always_comb begin
    bank_we = '0;
    if (state_r == ST_KEXP && idx_r[0]) bank_we[idx_r[2:1]] = 1'b1;
  end

  // Round key read address, set up the cycle before the key is used (registered RAM read)
  assign next_key = op_r ? (LastRound - 4'd1 - rnd_r) : (rnd_r + 4'd1);
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = in_op ? AW'(LastRound) : '0;
    end else if (rnd_r == LastRound) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(next_key);
    end
  end

  for (genvar b = 0; b < Banks; b++) begin : g_bank
    r256_ram #(.WIDTH(64), .DEPTH(BankDepth)) u_ram (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(wr_addr),
      .wdata({new_word, lo_r}),
      .raddr(rd_addr),
      .rdata(bank_rd[b])
    );
    assign rk[64*b +: 64] = bank_rd[b];
  end

  // Shared round unit
  assign enc_a = shift_sub(st_r);
  assign dec_a = inv_shift_sub(st_r) ^ rk;
  always_comb begin
    if (rnd_r == 4'd0) begin
      round_out = st_r ^ rk;
    end else if (!op_r) begin
      round_out = ((rnd_r == LastRound) ? enc_a : mix(enc_a)) ^ rk;
    end else begin
      round_out = (rnd_r == LastRound) ? dec_a : inv_mix(dec_a);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_RUN;
      ST_KEXP: if (idx_r == IW'(SchedWords - 1)) state_nxt = ST_IDLE;
      ST_RUN:  if (rnd_r == LastRound) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) state_nxt = ST_KEXP;
  end

  // Hold the round counter at the last round once the block is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KEXP;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) rnd_r <= '0;
      else if (state_r == ST_RUN && rnd_r != LastRound) rnd_r <= rnd_r + 4'd1;
    end
  end

  // Working block
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_r <= {in_block_word3, in_block_word2, in_block_word1, in_block_word0};
      op_r <= in_op;
    end else if (state_r == ST_RUN) begin
      st_r <= round_out;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_r       <= st_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word0 = out_r[63:0];
  assign out_word1 = out_r[127:64];
  assign out_word2 = out_r[191:128];
  assign out_word3 = out_r[255:192];

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !cfg_wr |=> state_r == ST_RUN && rnd_r == 4'd0)
    else $error("accepted block did not start at the first round");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && rnd_r == LastRound && !cfg_wr |=> state_r == ST_DONE)
    else $error("round sequence ran past the last round");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= LastRound)
    else $error("round counter out of range");

  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    bank_we != '0 |-> state_r == ST_KEXP && !in_ready)
    else $error("round key store written outside expansion");

endmodule

FILE: src/r256_ram.sv
// ----------------------------------------------------------------------------
// r256_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r256_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
